// ----- src/filtered_trace_ring_buffer_assert.svh -----
// Assertion macros for the filtered trace ring buffer.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef FILTERED_TRACE_RING_BUFFER_ASSERT_SVH
`define FILTERED_TRACE_RING_BUFFER_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define FTRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define FTRB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (cons)) else $error(msg);

`endif

// ----- src/ftrb_pkg.sv -----
// Package for the filtered trace ring buffer: sizes, codes, beat and
// memory request types. No dependencies.
package ftrb_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int IDW = 22;
  localparam int STW = 32;
  localparam int NMW = 64;
  localparam int CNTW = 32;
  localparam int COPYW = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GROUP = 2'd2;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FILTERED  = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } fsm_e;

  typedef struct packed {
    logic [IDW-1:0] group_id;
    logic [IDW-1:0] thread_id;
    logic [STW-1:0] task_state;
    logic [NMW-1:0] name_high;
    logic [NMW-1:0] name_low;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic            trace_enable;
    logic            filter_all;
    logic [IDW-1:0]  filter_group_id;
  } cfg_t;

  typedef struct packed {
    logic            strobe;
    logic            from_mem;
    status_e         status;
    logic [CW-1:0]   copied;
    logic [CNTW-1:0] next_count;
    logic            last;
  } res_ctl_t;

  // Advance a slot index around the ring.
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    logic [AW-1:0] r;
    if (s == AW'(DEPTH - 1)) r = '0;
    else r = s + AW'(1);
    return r;
  endfunction

endpackage

// ----- src/ftrb_cfg.sv -----
// Configuration registers of the filtered trace ring buffer.
// Depends on ftrb_pkg.
module ftrb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ftrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ftrb_pkg::CFG_DW-1:0]    cfg_wdata_i,
  output ftrb_pkg::cfg_t                 cfg_o
);
  import ftrb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TRACE_ENABLE: cfg_d.trace_enable = cfg_wdata_i[0];
        REG_FILTER_ALL:   cfg_d.filter_all = cfg_wdata_i[0];
        REG_FILTER_GROUP: cfg_d.filter_group_id = cfg_wdata_i[IDW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trace_enable    <= 1'b0;
      cfg_q.filter_all      <= 1'b1;
      cfg_q.filter_group_id <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- src/ftrb_store.sv -----
// Entry memory of the filtered trace ring buffer: one write port and one
// registered read port. Depends on ftrb_pkg.
module ftrb_store (
  input  logic               clk_i,
  input  ftrb_pkg::mem_req_t req_i,
  output ftrb_pkg::entry_t   rd_data_o
);
  import ftrb_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- src/ftrb_ctrl.sv -----
// Ring pointers, filter decision and readout sequencer of the filtered
// trace ring buffer. Depends on ftrb_pkg and the assertion header.
`include "filtered_trace_ring_buffer_assert.svh"

module ftrb_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind_i,
  input  logic [ftrb_pkg::IDW-1:0]  group_id_i,
  input  logic [ftrb_pkg::IDW-1:0]  thread_id_i,
  input  logic [ftrb_pkg::STW-1:0]  task_state_i,
  input  logic [ftrb_pkg::NMW-1:0]  name_high_i,
  input  logic [ftrb_pkg::NMW-1:0]  name_low_i,
  input  logic signed [ftrb_pkg::CNTW-1:0] after_count_i,
  input  ftrb_pkg::cfg_t            cfg_i,
  output ftrb_pkg::mem_req_t        req_o,
  output ftrb_pkg::res_ctl_t        res_o
);
  import ftrb_pkg::*;

  fsm_e            state_q, state_d;
  logic [AW-1:0]   oldest_q, oldest_d;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CNTW-1:0] dropped_q, dropped_d;
  logic            plain_q, plain_d;
  status_e         plain_status_q, plain_status_d;
  logic [CNTW-1:0] plain_next_q, plain_next_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   copy_q, copy_d;
  logic [CNTW-1:0] rd_next_q, rd_next_d;

  logic                 accept;
  logic                 full;
  logic                 hit;
  logic [CNTW-2:0]      cnt;
  logic [CNTW:0]        have;
  logic [CNTW:0]        need;
  logic signed [CNTW+1:0] diff;
  logic [CW-1:0]        copy_cnt;
  logic [AW:0]          slot_sum;
  logic [AW-1:0]        slot_app;
  logic                 last_beat;

  assign busy   = (state_q == S_READ);
  assign accept = start && !busy;
  assign full   = (fill_q == CW'(DEPTH));
  assign hit    = cfg_i.trace_enable &&
                  (cfg_i.filter_all || (group_id_i == cfg_i.filter_group_id));

  // Append slot: oldest plus fill, wrapped once.
  assign slot_sum = {1'b0, oldest_q} + (AW + 1)'(fill_q);
  assign slot_app = (slot_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(slot_sum - (AW + 1)'(DEPTH)) : slot_sum[AW-1:0];

  // Readiness and copy count for a positive counter.
  assign cnt  = after_count_i[CNTW-2:0];
  assign have = {1'b0, dropped_q} + (CNTW + 1)'(fill_q);
  assign need = (CNTW + 1)'(cnt) + (CNTW + 1)'(DEPTH);
  assign diff = $signed((CNTW + 2)'(fill_q)) + $signed((CNTW + 2)'(cnt))
              - $signed({2'b00, dropped_q});

  always_comb begin
    if (cnt == '0) copy_cnt = fill_q;
    else if (diff > 0) copy_cnt = diff[CW-1:0];
    else copy_cnt = '0;
  end

  assign last_beat = (idx_q == copy_q);

  always_comb begin
    state_d        = state_q;
    oldest_d       = oldest_q;
    fill_d         = fill_q;
    dropped_d      = dropped_q;
    plain_d        = 1'b0;
    plain_status_d = ST_OK;
    plain_next_d   = '0;
    rd_ptr_d       = rd_ptr_q;
    idx_d          = idx_q;
    copy_d         = copy_q;
    rd_next_d      = rd_next_q;

    req_o.we                = 1'b0;
    req_o.waddr             = slot_app;
    req_o.wdata.group_id    = group_id_i;
    req_o.wdata.thread_id   = thread_id_i;
    req_o.wdata.task_state  = task_state_i;
    req_o.wdata.name_high   = name_high_i;
    req_o.wdata.name_low    = name_low_i;
    req_o.re                = 1'b0;
    req_o.raddr             = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          plain_d = 1'b1;
          case (kind_i)
            KIND_RECORD: begin
              if (hit) begin
                req_o.we = 1'b1;
                if (full) begin
                  // Overwrite the oldest entry and drop it.
                  req_o.waddr = oldest_q;
                  oldest_d    = slot_inc(oldest_q);
                  dropped_d   = dropped_q + CNTW'(1);
                end else begin
                  fill_d = fill_q + CW'(1);
                end
              end else begin
                plain_status_d = ST_FILTERED;
              end
            end
            KIND_READ: begin
              if (after_count_i[CNTW-1]) begin
                plain_status_d = ST_BAD_COUNT;
              end else if ((cnt != '0) && (have < need)) begin
                plain_status_d = ST_NOT_READY;
              end else if (copy_cnt == '0) begin
                plain_next_d = dropped_q;
              end else begin
                plain_d     = 1'b0;
                state_d     = S_READ;
                req_o.re    = 1'b1;
                req_o.raddr = oldest_q;
                rd_ptr_d    = slot_inc(oldest_q);
                idx_d       = CW'(1);
                copy_d      = copy_cnt;
                rd_next_d   = dropped_q + CNTW'(copy_cnt);
              end
            end
            KIND_CLEAR: begin
              fill_d    = '0;
              dropped_d = '0;
            end
            default: plain_status_d = ST_OK;
          endcase
        end
      end
      S_READ: begin
        if (last_beat) begin
          state_d = S_IDLE;
        end else begin
          req_o.re = 1'b1;
          rd_ptr_d = slot_inc(rd_ptr_q);
          idx_d    = idx_q + CW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o.strobe     = 1'b0;
    res_o.from_mem   = 1'b0;
    res_o.status     = ST_OK;
    res_o.copied     = '0;
    res_o.next_count = '0;
    res_o.last       = 1'b0;
    if (state_q == S_READ) begin
      res_o.strobe     = 1'b1;
      res_o.from_mem   = 1'b1;
      res_o.copied     = copy_q;
      res_o.next_count = rd_next_q;
      res_o.last       = last_beat;
    end else if (plain_q) begin
      res_o.strobe     = 1'b1;
      res_o.status     = plain_status_q;
      res_o.next_count = plain_next_q;
      res_o.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      oldest_q  <= '0;
      fill_q    <= '0;
      dropped_q <= '0;
      plain_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
      plain_q   <= plain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plain_status_q <= plain_status_d;
    plain_next_q   <= plain_next_d;
    rd_ptr_q       <= rd_ptr_d;
    idx_q          <= idx_d;
    copy_q         <= copy_d;
    rd_next_q      <= rd_next_d;
  end

  `FTRB_ASSERT(a_fill_bound, fill_q <= CW'(DEPTH), "fill level above depth")
  `FTRB_ASSERT(a_no_write_in_read, !(req_o.we && busy), "write during readout")
  `FTRB_ASSERT(a_one_source, !(plain_q && busy), "two result sources at once")
  `FTRB_ASSERT_NEXT(a_burst_holds, busy && !last_beat, busy, "readout cut short")
  `FTRB_ASSERT_NEXT(a_burst_ends, busy && last_beat, !busy, "readout overruns")

endmodule

// ----- src/filtered_trace_ring_buffer.sv -----
// Filtered trace ring buffer top, 64 entries, oldest overwritten when full.
// Built from ftrb_cfg, ftrb_ctrl and ftrb_store; depends on ftrb_pkg.
// Record, clear, failed or empty read: result in the cycle after acceptance; a record
// can be issued every cycle while busy is low. A read of N entries streams N beats,
// one per cycle starting in the cycle after acceptance, with busy high while they stream.
// Async active-low reset empties the ring and loads defaults; results cannot stall.
module filtered_trace_ring_buffer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command side.
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind_i,
  input  logic [ftrb_pkg::IDW-1:0]          group_id_i,
  input  logic [ftrb_pkg::IDW-1:0]          thread_id_i,
  input  logic [ftrb_pkg::STW-1:0]          task_state_i,
  input  logic [ftrb_pkg::NMW-1:0]          name_high_i,
  input  logic [ftrb_pkg::NMW-1:0]          name_low_i,
  input  logic signed [ftrb_pkg::CNTW-1:0]  after_count_i,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ftrb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ftrb_pkg::CFG_DW-1:0]       cfg_wdata_i,
  // Result beats.
  output logic                              strobe_o,
  output logic [1:0]                        status_o,
  output logic                              rec_valid_o,
  output logic [ftrb_pkg::IDW-1:0]          rec_group_id_o,
  output logic [ftrb_pkg::IDW-1:0]          rec_thread_id_o,
  output logic [ftrb_pkg::STW-1:0]          rec_state_o,
  output logic [ftrb_pkg::NMW-1:0]          rec_name_high_o,
  output logic [ftrb_pkg::NMW-1:0]          rec_name_low_o,
  output logic [ftrb_pkg::COPYW-1:0]        copied_count_o,
  output logic [ftrb_pkg::CNTW-1:0]         next_count_o,
  output logic                              last_o
);
  import ftrb_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  entry_t   rd_data;
  res_ctl_t res;

  // Filter and enable registers.
  ftrb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pointers, counters and the readout sequencer; drives the memory port.
  ftrb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .group_id_i    (group_id_i),
    .thread_id_i   (thread_id_i),
    .task_state_i  (task_state_i),
    .name_high_i   (name_high_i),
    .name_low_i    (name_low_i),
    .after_count_i (after_count_i),
    .cfg_i         (cfg),
    .req_o         (mem_req),
    .res_o         (res)
  );

  // Entry storage; read data lands in the cycle after the request, in step
  // with the readout beat that the sequencer presents.
  ftrb_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Assemble the result beat; entry fields are zero unless a stored entry
  // is being returned.
  always_comb begin
    strobe_o        = res.strobe;
    status_o        = res.status;
    rec_valid_o     = res.from_mem;
    copied_count_o  = COPYW'(res.copied);
    next_count_o    = res.next_count;
    last_o          = res.last;
    rec_group_id_o  = '0;
    rec_thread_id_o = '0;
    rec_state_o     = '0;
    rec_name_high_o = '0;
    rec_name_low_o  = '0;
    if (res.from_mem) begin
      rec_group_id_o  = rd_data.group_id;
      rec_thread_id_o = rd_data.thread_id;
      rec_state_o     = rd_data.task_state;
      rec_name_high_o = rd_data.name_high;
      rec_name_low_o  = rd_data.name_low;
    end
  end

endmodule

// ----- dv/tb_filtered_trace_ring_buffer.sv -----
// Self-checking testbench for filtered_trace_ring_buffer: drives record, read and clear
// commands, predicts every result beat and compares the beats as they stream out.
// Depends on ftrb_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_filtered_trace_ring_buffer;
  import ftrb_pkg::*;

  // The block ignores kind 3 and answers it with a plain ok beat.
  localparam logic [1:0]     KIND_UNUSED = 2'd3;
  localparam logic [IDW-1:0] GROUP_MAX   = '1;
  localparam int unsigned    CYCLE_LIMIT = 250000;

  // One command as the sender sees it.
  typedef struct {
    logic [1:0]             kind;
    logic [IDW-1:0]         group_id;
    logic [IDW-1:0]         thread_id;
    logic [STW-1:0]         task_state;
    logic [NMW-1:0]         name_high;
    logic [NMW-1:0]         name_low;
    logic signed [CNTW-1:0] after_count;
  } trace_cmd_t;

  // One result beat as the block should present it.
  typedef struct {
    status_e          status;
    logic             rec_valid;
    entry_t           entry;
    logic [COPYW-1:0] copied;
    logic [CNTW-1:0]  next_count;
    logic             last;
  } trace_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             kind_i = '0;
  logic [IDW-1:0]         group_id_i = '0;
  logic [IDW-1:0]         thread_id_i = '0;
  logic [STW-1:0]         task_state_i = '0;
  logic [NMW-1:0]         name_high_i = '0;
  logic [NMW-1:0]         name_low_i = '0;
  logic signed [CNTW-1:0] after_count_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DW-1:0]      cfg_wdata_i = '0;
  logic                   strobe_o;
  logic [1:0]             status_o;
  logic                   rec_valid_o;
  logic [IDW-1:0]         rec_group_id_o;
  logic [IDW-1:0]         rec_thread_id_o;
  logic [STW-1:0]         rec_state_o;
  logic [NMW-1:0]         rec_name_high_o;
  logic [NMW-1:0]         rec_name_low_o;
  logic [COPYW-1:0]       copied_count_o;
  logic [CNTW-1:0]        next_count_o;
  logic                   last_o;

  filtered_trace_ring_buffer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .group_id_i      (group_id_i),
    .thread_id_i     (thread_id_i),
    .task_state_i    (task_state_i),
    .name_high_i     (name_high_i),
    .name_low_i      (name_low_i),
    .after_count_i   (after_count_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .rec_valid_o     (rec_valid_o),
    .rec_group_id_o  (rec_group_id_o),
    .rec_thread_id_o (rec_thread_id_o),
    .rec_state_o     (rec_state_o),
    .rec_name_high_o (rec_name_high_o),
    .rec_name_low_o  (rec_name_low_o),
    .copied_count_o  (copied_count_o),
    .next_count_o    (next_count_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the ring and its registers, advanced once per accepted command.
  entry_t          ring_mem [DEPTH];
  int              ring_oldest = 0;
  int              ring_fill = 0;
  logic [CNTW-1:0] ring_dropped = '0;
  logic            en_trace = 1'b0;
  logic            en_all = 1'b1;
  logic [IDW-1:0]  traced_group = '0;

  // Beats still owed by the block, oldest first.
  trace_beat_t     pending_beats [$];
  int unsigned     error_count = 0;

  // Single-beat answer: records, clears, failed reads and ignored kinds.
  function automatic trace_beat_t plain_beat(input status_e st);
    trace_beat_t b;
    b.status     = st;
    b.rec_valid  = 1'b0;
    b.entry      = '0;
    b.copied     = '0;
    b.next_count = '0;
    b.last       = 1'b1;
    return b;
  endfunction

  // Advance the shadow ring by one command and queue the beats it must produce.
  function automatic void predict_ring_beats(input trace_cmd_t cmd);
    trace_beat_t b;
    longint      after_l;
    longint      dropped_l;
    longint      n_copy;
    int          slot;
    case (cmd.kind)
      KIND_RECORD: begin
        if (!(en_trace && (en_all || cmd.group_id == traced_group))) begin
          pending_beats.push_back(plain_beat(ST_FILTERED));
        end else begin
          // Full ring: drop the oldest entry to make room.
          if (ring_fill >= DEPTH) begin
            ring_oldest  = (ring_oldest + 1) % DEPTH;
            ring_dropped = ring_dropped + 1'b1;
            ring_fill    = ring_fill - 1;
          end
          slot = (ring_oldest + ring_fill) % DEPTH;
          ring_mem[slot].group_id   = cmd.group_id;
          ring_mem[slot].thread_id  = cmd.thread_id;
          ring_mem[slot].task_state = cmd.task_state;
          ring_mem[slot].name_high  = cmd.name_high;
          ring_mem[slot].name_low   = cmd.name_low;
          ring_fill = ring_fill + 1;
          pending_beats.push_back(plain_beat(ST_OK));
        end
      end
      KIND_READ: begin
        after_l   = cmd.after_count;
        dropped_l = ring_dropped;
        if (after_l < 0) begin
          pending_beats.push_back(plain_beat(ST_BAD_COUNT));
        end else if (after_l > 0 && dropped_l + ring_fill < after_l + DEPTH) begin
          // Window not yet complete: answer instead of blocking.
          pending_beats.push_back(plain_beat(ST_NOT_READY));
        end else begin
          n_copy = ring_fill;
          if (after_l > 0) begin
            n_copy = ring_fill + after_l - dropped_l;
            if (n_copy < 0) n_copy = 0;
            if (n_copy > ring_fill) n_copy = ring_fill;
          end
          if (n_copy == 0) begin
            b = plain_beat(ST_OK);
            b.next_count = ring_dropped;
            pending_beats.push_back(b);
          end else begin
            for (longint i = 0; i < n_copy; i++) begin
              b.status     = ST_OK;
              b.rec_valid  = 1'b1;
              b.entry      = ring_mem[int'((ring_oldest + i) % DEPTH)];
              b.copied     = COPYW'(n_copy);
              b.next_count = CNTW'(dropped_l + n_copy);
              b.last       = (i == n_copy - 1);
              pending_beats.push_back(b);
            end
          end
        end
      end
      KIND_CLEAR: begin
        // The read position stays where it is.
        ring_fill    = 0;
        ring_dropped = '0;
        pending_beats.push_back(plain_beat(ST_OK));
      end
      default: pending_beats.push_back(plain_beat(ST_OK));
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [NMW-1:0] want,
                                      input logic [NMW-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  // Each strobed beat is taken at the edge that closes its cycle; the block cannot be
  // stalled, so compare against the oldest owed beat right away.
  always @(posedge clk_i) begin : beat_check
    trace_beat_t want;
    if (rst_ni && strobe_o !== 1'b0) begin
      if (pending_beats.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, expected none, actual status %0h", $time, status_o);
      end else begin
        want = pending_beats.pop_front();
        check_field("status", NMW'(want.status), NMW'(status_o));
        check_field("rec_valid", NMW'(want.rec_valid), NMW'(rec_valid_o));
        check_field("rec_group_id", NMW'(want.entry.group_id), NMW'(rec_group_id_o));
        check_field("rec_thread_id", NMW'(want.entry.thread_id), NMW'(rec_thread_id_o));
        check_field("rec_state", NMW'(want.entry.task_state), NMW'(rec_state_o));
        check_field("rec_name_high", want.entry.name_high, rec_name_high_o);
        check_field("rec_name_low", want.entry.name_low, rec_name_low_o);
        check_field("copied_count", NMW'(want.copied), NMW'(copied_count_o));
        check_field("next_count", NMW'(want.next_count), NMW'(next_count_o));
        check_field("last", NMW'(want.last), NMW'(last_o));
      end
    end
  end

  // Present a command and hold it until the block takes it; start stays high on
  // return so back-to-back commands need no extra edge.
  task automatic send_cmd(input trace_cmd_t cmd);
    kind_i        <= cmd.kind;
    group_id_i    <= cmd.group_id;
    thread_id_i   <= cmd.thread_id;
    task_state_i  <= cmd.task_state;
    name_high_i   <= cmd.name_high;
    name_low_i    <= cmd.name_low;
    after_count_i <= cmd.after_count;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_ring_beats(cmd);
  endtask

  // Drop start for a gap; a zero gap keeps the stream going.
  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_then_idle(input trace_cmd_t cmd, input bit steady);
    send_cmd(cmd);
    pause_sender(steady ? 0 : gap_cycles());
  endtask

  // Hold off until every owed beat is in and the block is idle, then settle.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_beats.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    drain_results();
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TRACE_ENABLE: en_trace = value[0];
      REG_FILTER_ALL:   en_all = value[0];
      REG_FILTER_GROUP: traced_group = value[IDW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input bit enable, input bit all_groups, input logic [IDW-1:0] grp);
    write_reg(REG_TRACE_ENABLE, CFG_DW'(enable));
    write_reg(REG_FILTER_ALL, CFG_DW'(all_groups));
    write_reg(REG_FILTER_GROUP, CFG_DW'(grp));
  endtask

  // Fully random payload; callers then pin the kind and whatever matters.
  function automatic trace_cmd_t random_cmd_fields();
    trace_cmd_t c;
    c.kind        = KIND_RECORD;
    c.group_id    = IDW'($urandom);
    c.thread_id   = IDW'($urandom);
    c.task_state  = $urandom;
    c.name_high   = {$urandom, $urandom};
    c.name_low    = {$urandom, $urandom};
    c.after_count = $urandom;
    return c;
  endfunction

  function automatic trace_cmd_t record_cmd(input logic [IDW-1:0] grp);
    trace_cmd_t c;
    c = random_cmd_fields();
    c.group_id = grp;
    return c;
  endfunction

  function automatic trace_cmd_t read_cmd(input logic [CNTW-1:0] after);
    trace_cmd_t c;
    c = random_cmd_fields();
    c.kind        = KIND_READ;
    c.after_count = after;
    return c;
  endfunction

  function automatic trace_cmd_t op_cmd(input logic [1:0] kind);
    trace_cmd_t c;
    c = random_cmd_fields();
    c.kind = kind;
    return c;
  endfunction

  // Mostly plain reads and counters around the dropped count, so ready reads with
  // partial windows show up; the rest are far-ahead and negative counters.
  function automatic logic [CNTW-1:0] pick_after_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return '0;
    if (r < 75) return $urandom_range(1, ring_dropped + 4);
    if (r < 85) return {1'b0, 31'($urandom)} | 32'd1;
    return $urandom | 32'h8000_0000;
  endfunction

  // Tracing is off after reset: every record is filtered, and the read edge cases
  // all answer with a single beat.
  task automatic test_reset_defaults();
    trace_cmd_t c;
    c = record_cmd(GROUP_MAX);
    c.thread_id  = '1;
    c.task_state = '1;
    c.name_high  = '1;
    c.name_low   = '1;
    send_cmd(c);
    send_cmd(read_cmd(32'd0));
    send_cmd(read_cmd(32'hFFFF_FFFF));
    send_cmd(read_cmd(32'h8000_0000));
    send_cmd(read_cmd(32'd1));
    send_cmd(read_cmd(32'h7FFF_FFFF));
    send_cmd(op_cmd(KIND_UNUSED));
    send_cmd(op_cmd(KIND_CLEAR));
  endtask

  // Store all-zero, all-one and random events, then read them back.
  task automatic test_record_readback();
    trace_cmd_t c;
    configure(1'b1, 1'b1, '0);
    c = record_cmd('0);
    c.thread_id  = '0;
    c.task_state = '0;
    c.name_high  = '0;
    c.name_low   = '0;
    send_cmd(c);
    c.group_id   = '1;
    c.thread_id  = '1;
    c.task_state = '1;
    c.name_high  = '1;
    c.name_low   = '1;
    send_cmd(c);
    send_cmd(record_cmd(IDW'($urandom)));
    send_cmd(read_cmd(32'd0));
    send_cmd(read_cmd(32'd1));
  endtask

  // Single-group filtering at both ends of the group range.
  task automatic test_group_filter();
    configure(1'b1, 1'b0, GROUP_MAX);
    send_cmd(record_cmd(GROUP_MAX));
    send_cmd(record_cmd('0));
    send_cmd(record_cmd(GROUP_MAX - 1'b1));
    configure(1'b1, 1'b0, '0);
    send_cmd(record_cmd('0));
    send_cmd(record_cmd(GROUP_MAX));
    send_cmd(read_cmd(32'd0));
  endtask

  // Clear empties the ring; new records land at the old read position.
  task automatic test_clear();
    send_cmd(op_cmd(KIND_CLEAR));
    send_cmd(read_cmd(32'd0));
    send_cmd(record_cmd(traced_group));
    send_cmd(read_cmd(32'd0));
  endtask

  // Bursts of records, long enough now and then to wrap the ring, each followed by
  // reads; clears, ignored kinds and full drains are sprinkled in. Every command
  // sent counts toward the budget.
  task automatic run_random_phase(input int unsigned budget, input bit steady);
    int unsigned counted;
    int unsigned burst;
    int unsigned r;
    trace_cmd_t  c;
    counted = 0;
    while (counted < budget) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
      repeat (burst) begin
        c = random_cmd_fields();
        if (!en_all && $urandom_range(0, 9) < 7) c.group_id = traced_group;
        send_then_idle(c, steady);
        counted++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_then_idle(read_cmd(pick_after_count()), steady);
        counted++;
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_then_idle(op_cmd(KIND_CLEAR), steady);
        counted++;
      end else if (r == 1) begin
        send_then_idle(op_cmd(KIND_UNUSED), steady);
        counted++;
      end else if (r == 2) begin
        drain_results();
      end
    end
  endtask

  task automatic test_random_traffic();
    configure(1'b1, 1'b1, IDW'($urandom));
    run_random_phase(80, 1'b0);
    configure(1'b1, 1'b0, IDW'($urandom));
    run_random_phase(60, 1'b0);
    configure(1'b1, 1'b0, GROUP_MAX);
    run_random_phase(40, 1'b0);
    configure(1'b1, 1'b0, '0);
    run_random_phase(30, 1'b1);
    configure(1'b0, 1'b1, IDW'($urandom));
    run_random_phase(15, 1'b0);
    configure(1'b1, 1'b1, '0);
    run_random_phase(25, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_record_readback();
    test_group_filter();
    test_clear();
    test_random_traffic();
    // Wait out the last read stream, then idle on to catch stray beats.
    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** filtered_trace_ring_buffer: PASSED **");
    end else begin
      $display("** filtered_trace_ring_buffer: FAILED **");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout", $time);
    $display("** filtered_trace_ring_buffer: FAILED **");
    $finish;
  end

endmodule
